@@ hw/rtl/htd_pkg.sv @@
// Shared types and constants of the Huffman tree-walk decoder.
// Used by htd_ctrl and huffman_tree_decoder_top; depends on nothing.

package htd_pkg;

  // Table size and code length limits.
  localparam int MAX_NODES    = 512;
  localparam int MAX_CODE_LEN = 32;

  // Field widths of one beat.
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;

  // Derived widths.
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int BIT_W     = $clog2(CODE_W);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  localparam int IN_TDATA_W  = ((CODE_W + LEN_W + SYM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SYM_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_DECODE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // One table entry; a child index of zero means no child.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    logic [SYM_W-1:0]  symbol;
  } cmd_t;

  typedef struct packed {
    logic             sym_valid;
    logic [SYM_W-1:0] sym;
    status_e          status;
  } res_t;

endpackage

@@ hw/rtl/htd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the node table.

module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/htd_ctrl.sv @@
// Sequencer and tree-walk step unit of the Huffman decoder.
// Depends on htd_pkg and htd_ram (node table, nodes 1 upwards; the root lives in flops).

module htd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  htd_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output htd_pkg::res_t res_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ADD_RD   = 8'b0000_0010,
    S_ADD_EV   = 8'b0000_0100,
    S_ADD_LINK = 8'b0000_1000,
    S_DEC_RD   = 8'b0001_0000,
    S_DEC_EV   = 8'b0010_0000,
    S_DEC_CHK  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [htd_pkg::IDX_W-1:0] root_left_q, root_left_d;
  logic [htd_pkg::IDX_W-1:0] root_right_q, root_right_d;
  logic [htd_pkg::CNT_W-1:0] count_q, count_d;
  logic [htd_pkg::IDX_W-1:0] walk_q, walk_d;

  // Working registers of the current item.
  logic [htd_pkg::IDX_W-1:0]  pos_q, pos_d;
  logic [htd_pkg::CODE_W-1:0] bits_q, bits_d;
  logic [htd_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic [htd_pkg::SYM_W-1:0]  sym_q, sym_d;
  htd_pkg::res_t              res_q, res_d;

  // Node table port signals.
  logic                      ram_we;
  logic [htd_pkg::IDX_W-1:0] ram_waddr;
  htd_pkg::node_t            ram_wdata;
  logic                      ram_re;
  logic [htd_pkg::IDX_W-1:0] ram_raddr;
  htd_pkg::node_t            ram_rdata;

  // Step unit signals.
  htd_pkg::node_t            node_cur;
  htd_pkg::node_t            node_upd;
  logic [htd_pkg::LEN_W-1:0] bit_sel;
  logic                      add_bit;
  logic                      cur_bit;
  logic [htd_pkg::IDX_W-1:0] child;
  logic [htd_pkg::IDX_W-1:0] new_idx;
  logic [htd_pkg::LEN_W-1:0] len_clip;

  htd_ram #(
    .WIDTH($bits(htd_pkg::node_t)),
    .DEPTH(htd_pkg::MAX_NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Step unit: current node, selected bit and the child it points to.
  always_comb begin
    if (pos_q == '0) begin
      node_cur.sym   = '0;
      node_cur.left  = root_left_q;
      node_cur.right = root_right_q;
    end else begin
      node_cur = ram_rdata;
    end
    bit_sel = rem_q - htd_pkg::LEN_W'(1);
    add_bit = bits_q[bit_sel[htd_pkg::BIT_W-1:0]];
    // Both add states follow the code bit; a decode follows bit 0.
    cur_bit = (state_q == S_ADD_EV || state_q == S_ADD_LINK) ? add_bit : bits_q[0];
    child   = cur_bit ? node_cur.right : node_cur.left;
    new_idx = count_q[htd_pkg::IDX_W-1:0];
    // Parent entry with the new child linked in.
    node_upd = node_cur;
    if (cur_bit) begin
      node_upd.right = new_idx;
    end else begin
      node_upd.left = new_idx;
    end
  end

  // Code length limited to the supported maximum.
  assign len_clip = (cmd_i.code_len > htd_pkg::LEN_W'(htd_pkg::LEN_LIMIT)) ?
                    htd_pkg::LEN_W'(htd_pkg::LEN_LIMIT) : cmd_i.code_len;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    root_left_d  = root_left_q;
    root_right_d = root_right_q;
    count_d      = count_q;
    walk_d       = walk_q;
    pos_d        = pos_q;
    bits_d       = bits_q;
    rem_d        = rem_q;
    sym_d        = sym_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = pos_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          bits_d = cmd_i.code_bits;
          sym_d  = cmd_i.symbol;
          rem_d  = len_clip;
          res_d  = '0;
          case (cmd_i.op)
            htd_pkg::OP_CLEAR: begin
              root_left_d  = '0;
              root_right_d = '0;
              count_d      = htd_pkg::CNT_W'(1);
              walk_d       = '0;
              state_d      = S_DONE;
            end
            htd_pkg::OP_ADD: begin
              pos_d   = '0;
              state_d = (len_clip == '0) ? S_DONE : S_ADD_RD;
            end
            htd_pkg::OP_DECODE: begin
              pos_d   = walk_q;
              state_d = S_DEC_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_ADD_RD: begin
        ram_re  = (pos_q != '0);
        state_d = S_ADD_EV;
      end

      S_ADD_EV: begin
        if (child != '0) begin
          pos_d   = child;
          rem_d   = rem_q - htd_pkg::LEN_W'(1);
          state_d = (rem_q == htd_pkg::LEN_W'(1)) ? S_DONE : S_ADD_RD;
        end else if (count_q == htd_pkg::CNT_W'(htd_pkg::MAX_NODES)) begin
          res_d.status = htd_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          // Create the new node; the parent is linked in the next cycle.
          ram_we          = 1'b1;
          ram_waddr       = new_idx;
          ram_wdata.sym   = sym_q;
          ram_wdata.left  = '0;
          ram_wdata.right = '0;
          state_d         = S_ADD_LINK;
        end
      end

      S_ADD_LINK: begin
        if (pos_q == '0) begin
          root_left_d  = node_upd.left;
          root_right_d = node_upd.right;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = node_upd;
        end
        count_d = count_q + htd_pkg::CNT_W'(1);
        pos_d   = new_idx;
        rem_d   = rem_q - htd_pkg::LEN_W'(1);
        state_d = (rem_q == htd_pkg::LEN_W'(1)) ? S_DONE : S_ADD_RD;
      end

      S_DEC_RD: begin
        ram_re  = (pos_q != '0);
        state_d = S_DEC_EV;
      end

      S_DEC_EV: begin
        if (child == '0) begin
          res_d.status = htd_pkg::ST_MISSING;
          walk_d       = '0;
          state_d      = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = child;
          pos_d     = child;
          state_d   = S_DEC_CHK;
        end
      end

      S_DEC_CHK: begin
        // A node without children is a leaf: emit and return to the root.
        if (ram_rdata.left == '0 && ram_rdata.right == '0) begin
          res_d.sym_valid = 1'b1;
          res_d.sym       = ram_rdata.sym;
          walk_d          = '0;
        end else begin
          walk_d = pos_q;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      root_left_q  <= '0;
      root_right_q <= '0;
      count_q      <= htd_pkg::CNT_W'(1);
      walk_q       <= '0;
    end else begin
      state_q      <= state_d;
      root_left_q  <= root_left_d;
      root_right_q <= root_right_d;
      count_q      <= count_d;
      walk_q       <= walk_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    bits_q <= bits_d;
    rem_q  <= rem_d;
    sym_q  <= sym_d;
    res_q  <= res_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

@@ hw/rtl/huffman_tree_decoder_top.sv @@
// Huffman tree-walk decoder: top level with stream ports and result register.
// Depends on htd_pkg and htd_ctrl.
//
// Usage: each input beat carries one command, selected by s_axis_tuser:
// clear the node table, add one code (bits MSB first, length, symbol) or
// decode one bit. Every command gives exactly one result beat on the
// master side: a symbol flag, the decoded symbol and a status code
// (ok, missing branch, table full).
// Clear, unused opcodes and empty codes go straight to the result. A
// decode bit reads the current node and picks its child; a missing branch
// ends there, else the child is read to see if it is a leaf. An add reads
// each node along the code and links in a new node where one is missing.
// The walk is set by one node-table read
// port with registered data; one item is worked on at a time, and
// s_axis_tready is low while the sequencer is busy.
// Reset leaves a childless root and the walk at the root; the rest of the
// table is not cleared.
// A result waits in the output register while m_axis_tready is low; the
// next command is still accepted and runs up to its own result, which
// then waits for the register to free.

module huffman_tree_decoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command beat; tdata from bit 0: code_bits[31:0], code_len[37:32],
  // symbol[45:38], zero padding.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [htd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [1:0]                         s_axis_tuser,
  // Result beat; tdata from bit 0: symbol_out[7:0].
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [htd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser from bit 0: symbol_valid[0], status[2:1].
  output logic [2:0]                         m_axis_tuser
);

  htd_pkg::cmd_t cmd;
  htd_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic          out_valid_q, out_valid_d;
  htd_pkg::res_t out_q, out_d;

  // Unpack the command beat.
  always_comb begin
    cmd.op        = htd_pkg::op_e'(s_axis_tuser);
    cmd.code_bits = s_axis_tdata[htd_pkg::CODE_W-1:0];
    cmd.code_len  = s_axis_tdata[htd_pkg::CODE_W +: htd_pkg::LEN_W];
    cmd.symbol    = s_axis_tdata[htd_pkg::CODE_W + htd_pkg::LEN_W +: htd_pkg::SYM_W];
  end

  htd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(s_axis_tvalid),
    .cmd_ready_o(s_axis_tready),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: loads when empty or when its beat is taken.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Pack the result beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = htd_pkg::OUT_TDATA_W'(out_q.sym);
  assign m_axis_tuser  = {out_q.status, out_q.sym_valid};

`ifndef SYNTHESIS
  // The sequencer is busy in the cycle after it takes a command.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while previous one still running");

  // No result is offered while the sequencer waits for a command.
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid)
    else $error("result offered in idle state");

  // A decoded symbol always comes with an ok status.
  a_leaf_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.sym_valid |-> out_q.status == htd_pkg::ST_OK)
    else $error("symbol emitted with error status");

  // Without a decoded symbol the symbol field is zero.
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.sym_valid |-> out_q.sym == '0)
    else $error("stale symbol on a result without a leaf");
`endif

endmodule

@@ tb/huffman_tree_decoder_top_tb.sv @@
// Self-checking testbench for the Huffman tree-walk decoder top level.
// Depends on htd_pkg and huffman_tree_decoder_top, which in turn needs htd_ctrl and htd_ram.
// A directed table, then random code books, table fills and noise, all checked on the fly.
`timescale 1ns / 100ps

module huffman_tree_decoder_top_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int N_DIRECTED     = 25;

  // Opcode that the block leaves unused, and the symbol of a fresh root.
  localparam logic [1:0]                OP_UNUSED = 2'd3;
  localparam logic [htd_pkg::SYM_W-1:0] ROOT_SYM  = 8'h20;

  localparam htd_pkg::res_t RES_OK =
    '{sym_valid: 1'b0, sym: '0, status: htd_pkg::ST_OK};
  localparam htd_pkg::res_t RES_MISSING =
    '{sym_valid: 1'b0, sym: '0, status: htd_pkg::ST_MISSING};
  localparam htd_pkg::res_t PREDICT = '0;

  // One row of the directed table; the result is used only where given is set.
  typedef struct {
    logic [1:0]                 op;
    logic [htd_pkg::CODE_W-1:0] bits;
    logic [htd_pkg::LEN_W-1:0]  len;
    logic [htd_pkg::SYM_W-1:0]  symbol;
    bit                         given;
    htd_pkg::res_t              result;
  } dir_row_t;

  dir_row_t directed_rows [N_DIRECTED] = '{
    // A childless root cannot be decoded.
    '{htd_pkg::OP_DECODE, 32'h0000_0000, 6'd0,  8'h00, 1'b1, RES_MISSING},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b1, RES_MISSING},
    // The unused opcode and an empty code change nothing.
    '{OP_UNUSED,          32'hFFFF_FFFF, 6'd63, 8'hFF, 1'b1, RES_OK},
    '{htd_pkg::OP_ADD,    32'hFFFF_FFFF, 6'd0,  8'hFF, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b1, RES_MISSING},
    // Small book: 0 -> 0x41, 10 -> 0x42, 11 -> 0xFF.
    '{htd_pkg::OP_ADD,    32'h0000_0000, 6'd1,  8'h41, 1'b1, RES_OK},
    '{htd_pkg::OP_ADD,    32'h0000_0002, 6'd2,  8'h42, 1'b1, RES_OK},
    '{htd_pkg::OP_ADD,    32'h0000_0003, 6'd2,  8'hFF, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0000, 6'd0,  8'h00, 1'b1,
      '{1'b1, 8'h41, htd_pkg::ST_OK}},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b1, RES_OK},
    // An add in the middle of a walk leaves the walk where it was.
    '{htd_pkg::OP_ADD,    32'h0000_0000, 6'd1,  8'h00, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b1,
      '{1'b1, 8'hFF, htd_pkg::ST_OK}},
    // Only bit 0 of a decode beat counts.
    '{htd_pkg::OP_DECODE, 32'hFFFF_FFFE, 6'd63, 8'hFF, 1'b1,
      '{1'b1, 8'h41, htd_pkg::ST_OK}},
    // Over-long code is cut to 32 bits; it turns the 11 leaf into an inner node.
    '{htd_pkg::OP_ADD,    32'hFFFF_FFFF, 6'd63, 8'h00, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b0, PREDICT},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b0, PREDICT},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b0, PREDICT},
    '{htd_pkg::OP_ADD,    32'h0000_0000, 6'd32, 8'h80, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0000, 6'd0,  8'h00, 1'b0, PREDICT},
    '{htd_pkg::OP_DECODE, 32'h0000_0000, 6'd0,  8'h00, 1'b0, PREDICT},
    // Clear empties the table back to a childless root.
    '{htd_pkg::OP_CLEAR,  32'hFFFF_FFFF, 6'd63, 8'hFF, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0000, 6'd0,  8'h00, 1'b1, RES_MISSING},
    '{htd_pkg::OP_ADD,    32'h0000_0001, 6'd1,  8'h07, 1'b1, RES_OK},
    '{htd_pkg::OP_DECODE, 32'h0000_0001, 6'd0,  8'h00, 1'b1,
      '{1'b1, 8'h07, htd_pkg::ST_OK}},
    '{htd_pkg::OP_DECODE, 32'h0000_0000, 6'd0,  8'h00, 1'b1, RES_MISSING}
  };

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [htd_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [1:0]                       s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [htd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [2:0]                       m_axis_tuser;

  // Shadow copy of the node table and the walk.
  htd_pkg::node_t            shadow_tree [htd_pkg::MAX_NODES];
  int                        node_total;
  logic [htd_pkg::IDX_W-1:0] walk_node;

  htd_pkg::res_t pending_results [$];
  int            mismatch_count = 0;
  int            sent_items     = 0;
  int            idle_cycles    = 0;
  bit            src_burst      = 1'b0;
  bit            sink_burst     = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  huffman_tree_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Empty the shadow table down to a childless root.
  function automatic void clear_tree();
    shadow_tree[0] = '{sym: ROOT_SYM, left: '0, right: '0};
    node_total     = 1;
    walk_node      = '0;
  endfunction

  // Apply one command to the shadow table and return the result it gives.
  function automatic htd_pkg::res_t walk_tree(logic [1:0] op,
                                              logic [htd_pkg::CODE_W-1:0] bits,
                                              logic [htd_pkg::LEN_W-1:0] len,
                                              logic [htd_pkg::SYM_W-1:0] symbol);
    htd_pkg::res_t             r;
    int                        eff;
    int                        i;
    logic                      b;
    logic [htd_pkg::IDX_W-1:0] pos;
    logic [htd_pkg::IDX_W-1:0] child;
    r = RES_OK;
    case (op)
      htd_pkg::OP_CLEAR: begin
        clear_tree();
      end
      htd_pkg::OP_ADD: begin
        eff = (int'(len) > htd_pkg::LEN_LIMIT) ? htd_pkg::LEN_LIMIT : int'(len);
        pos = '0;
        for (i = 0; i < eff && r.status == htd_pkg::ST_OK; i++) begin
          b     = bits[eff-1-i];
          child = b ? shadow_tree[pos].right : shadow_tree[pos].left;
          if (child == '0) begin
            if (node_total >= htd_pkg::MAX_NODES) begin
              r.status = htd_pkg::ST_FULL;
            end else begin
              child = node_total[htd_pkg::IDX_W-1:0];
              shadow_tree[child] = '{sym: symbol, left: '0, right: '0};
              if (b) shadow_tree[pos].right = child;
              else   shadow_tree[pos].left  = child;
              node_total++;
            end
          end
          pos = child;
        end
      end
      htd_pkg::OP_DECODE: begin
        child = bits[0] ? shadow_tree[walk_node].right : shadow_tree[walk_node].left;
        if (child == '0) begin
          r.status  = htd_pkg::ST_MISSING;
          walk_node = '0;
        end else if (shadow_tree[child].left == '0 && shadow_tree[child].right == '0) begin
          r.sym_valid = 1'b1;
          r.sym       = shadow_tree[child].sym;
          walk_node   = '0;
        end else begin
          walk_node = child;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Offer one command beat, wait for it to be taken and record its result.
  task automatic send_cmd(input logic [1:0] op, input logic [htd_pkg::CODE_W-1:0] bits,
                          input logic [htd_pkg::LEN_W-1:0] len,
                          input logic [htd_pkg::SYM_W-1:0] symbol,
                          input bit given = 1'b0, input htd_pkg::res_t given_res = '0);
    int                             gap;
    logic [htd_pkg::IN_TDATA_W-1:0] word;
    htd_pkg::res_t                  predicted;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap  = src_burst ? 0 : $urandom_range(0, 6);
    word = '0;
    word[htd_pkg::CODE_W-1:0]                           = bits;
    word[htd_pkg::CODE_W +: htd_pkg::LEN_W]             = len;
    word[htd_pkg::CODE_W+htd_pkg::LEN_W +: htd_pkg::SYM_W] = symbol;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = walk_tree(op, bits, len, symbol);
    pending_results.insert(pending_results.size(), given ? given_res : predicted);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Build a random code book after a clear, then decode bit streams along it.
  // A deep session uses long codes so that the table runs full.
  task automatic run_session(input bit deep);
    logic [htd_pkg::CODE_W-1:0] book_bits [$];
    int                         book_len [$];
    int                         n_add;
    int                         n_dec;
    int                         len;
    int                         pick;
    int                         k;
    int                         j;
    logic [htd_pkg::CODE_W-1:0] bits;
    send_cmd(htd_pkg::OP_CLEAR, $urandom, htd_pkg::LEN_W'($urandom_range(0, 63)),
             htd_pkg::SYM_W'($urandom));
    n_add = deep ? 24 : $urandom_range(1, 12);
    for (k = 0; k < n_add; k++) begin
      pick = $urandom_range(0, 99);
      if (deep)           len = $urandom_range(24, 32);
      else if (pick < 5)  len = 0;
      else if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 90) len = $urandom_range(9, 16);
      else if (pick < 97) len = $urandom_range(17, 32);
      else                len = $urandom_range(33, 63);
      bits = $urandom;
      send_cmd(htd_pkg::OP_ADD, bits, htd_pkg::LEN_W'(len), htd_pkg::SYM_W'($urandom));
      if (len > 0) begin
        book_bits.insert(book_bits.size(), bits);
        book_len.insert(book_len.size(),
                        len > htd_pkg::LEN_LIMIT ? htd_pkg::LEN_LIMIT : len);
      end
    end
    n_dec = $urandom_range(8, 80);
    while (n_dec > 0) begin
      if (book_len.size() == 0 || $urandom_range(0, 9) == 0) begin
        send_cmd(htd_pkg::OP_DECODE, $urandom, htd_pkg::LEN_W'($urandom_range(0, 63)),
                 htd_pkg::SYM_W'($urandom));
        n_dec--;
      end else begin
        k = $urandom_range(0, book_len.size() - 1);
        for (j = book_len[k] - 1; j >= 0 && n_dec > 0; j--) begin
          bits = ($urandom & ~32'h1) | htd_pkg::CODE_W'(book_bits[k][j]);
          send_cmd(htd_pkg::OP_DECODE, bits, htd_pkg::LEN_W'($urandom_range(0, 63)),
                   htd_pkg::SYM_W'($urandom));
          n_dec--;
        end
      end
    end
  endtask

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endfunction

  // Stimulus: directed table, a forced table fill, then random sessions and noise.
  initial begin
    int i;
    int pick;
    clear_tree();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < N_DIRECTED; i++) begin
      send_cmd(directed_rows[i].op, directed_rows[i].bits, directed_rows[i].len,
               directed_rows[i].symbol, directed_rows[i].given, directed_rows[i].result);
    end
    wait_drained();
    run_session(1'b1);
    while (sent_items < N_DIRECTED + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_cmd(2'($urandom_range(0, 3)), $urandom,
                 htd_pkg::LEN_W'($urandom_range(0, 63)), htd_pkg::SYM_W'($urandom));
      end else begin
        run_session(pick < 14);
      end
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("huffman_tree_decoder_top_tb: clean");
    else $display("huffman_tree_decoder_top_tb: errors");
    $finish;
  end

  // Result side: random back-pressure, each beat checked against the oldest expectation.
  initial begin
    int            stall;
    htd_pkg::res_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result beat with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("symbol_valid", want.sym_valid, m_axis_tuser[0]);
        check_field("symbol_out", want.sym, m_axis_tdata[htd_pkg::SYM_W-1:0]);
        check_field("status", want.status, m_axis_tuser[2:1]);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("huffman_tree_decoder_top_tb: errors");
      $finish;
    end
  end

endmodule
